### rtl/hbk_pkg.sv
// ---------------------------------------------------------------------------
// hbk_pkg
// Shared types and constants for the boot keyboard report differ: event
// slot layout, usage codes and the report entry carried through the queue.
// ---------------------------------------------------------------------------
package hbk_pkg;

   localparam int KEY_SLOTS = 6;
   localparam int MOD_BITS  = 8;
   localparam int EVT_COUNT = MOD_BITS + 2 * KEY_SLOTS;

   localparam logic [7:0] ROLLOVER_CODE   = 8'h01;
   localparam logic [7:0] MOD_BASE_CODE   = 8'd224;
   localparam logic [7:0] LOWEST_REAL_KEY = 8'd3;

   localparam logic KIND_PRESS   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef logic [KEY_SLOTS-1:0][7:0] key_array_type;
   typedef logic [EVT_COUNT-1:0]      evt_mask_type;

   // event positions: modifier bits first, then per slot a release of the
   // old code followed by a press of the new code
   typedef struct packed {
      evt_mask_type  mask;
      logic [7:0]    mods;
      key_array_type old_keys;
      key_array_type new_keys;
   } report_entry_type;

   typedef struct packed {
      logic can_push;
      logic can_pop;
   } queue_status_type;

endpackage

### rtl/hbk_front.sv
// ---------------------------------------------------------------------------
// hbk_front
// Accepts reports, drops rollover reports, compares each report with the
// stored one and queues the set of events that it causes.
// ---------------------------------------------------------------------------
module hbk_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_mods,
   input  hbk_pkg::key_array_type    req_keys,
   input  hbk_pkg::queue_status_type q_status,
   output logic                      push,
   output hbk_pkg::report_entry_type push_entry
);
   import hbk_pkg::*;

   logic [7:0]    prev_mods_ff;
   logic [7:0]    prev_mods_in;
   key_array_type prev_keys_ff;
   key_array_type prev_keys_in;
   evt_mask_type  mask;
   logic          accept;
   logic          rollover;

   function automatic logic slot_has(key_array_type slots, logic [7:0] code);
      logic hit;
      hit = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
         hit = hit | (slots[j] == code);
      end
      return hit;
   endfunction

   assign req_stall = !q_status.can_push;
   assign accept    = req_valid && q_status.can_push;
   assign rollover  = (req_keys[0] == ROLLOVER_CODE);

   always_comb begin
      for (int i = 0; i < MOD_BITS; i++) begin
         mask[i] = req_mods[i] ^ prev_mods_ff[i];
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
         mask[MOD_BITS + 2*i]     = (prev_keys_ff[i] > LOWEST_REAL_KEY)
                                    && !slot_has(req_keys, prev_keys_ff[i]);
         mask[MOD_BITS + 2*i + 1] = (req_keys[i] > LOWEST_REAL_KEY)
                                    && !slot_has(prev_keys_ff, req_keys[i]);
      end
   end

   assign push                = accept && !rollover && (mask != '0);
   assign push_entry.mask     = mask;
   assign push_entry.mods     = req_mods;
   assign push_entry.old_keys = prev_keys_ff;
   assign push_entry.new_keys = req_keys;

   always_comb begin
      prev_mods_in = prev_mods_ff;
      prev_keys_in = prev_keys_ff;
      if (accept && !rollover) begin
         prev_mods_in = req_mods;
         prev_keys_in = req_keys;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_mods_ff <= '0;
         prev_keys_ff <= '0;
      end else begin
         prev_mods_ff <= prev_mods_in;
         prev_keys_ff <= prev_keys_in;
      end
   end

   a_rollover_holds_state: assert property (@(posedge clock) disable iff (reset)
      (accept && rollover) |=> ($stable(prev_mods_ff) && $stable(prev_keys_ff)))
      else $error("rollover report changed stored state");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      push |-> q_status.can_push)
      else $error("push into full queue");

   a_no_empty_push: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_entry.mask != '0))
      else $error("queued report with no events");

endmodule

### rtl/hbk_queue.sv
// ---------------------------------------------------------------------------
// hbk_queue
// Short queue of classified reports between the front and the back.
// ---------------------------------------------------------------------------
module hbk_queue #(
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  hbk_pkg::report_entry_type push_entry,
   input  logic                      pop,
   output hbk_pkg::report_entry_type pop_entry,
   output hbk_pkg::queue_status_type status
);
   import hbk_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   report_entry_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_push;
   logic             do_pop;

   assign status.can_push = (count_ff != FULL_CNT);
   assign status.can_pop  = (count_ff != '0);
   assign do_push         = push && status.can_push;
   assign do_pop          = pop && status.can_pop;
   assign pop_entry       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not drop on pop");

endmodule

### rtl/hbk_back.sv
// ---------------------------------------------------------------------------
// hbk_back
// Takes one classified report from the queue and emits its events in
// position order, one per cycle unless rsp_stall holds the output register.
// ---------------------------------------------------------------------------
module hbk_back (
   input  logic                      clock,
   input  logic                      reset,
   input  hbk_pkg::queue_status_type q_status,
   input  hbk_pkg::report_entry_type pop_entry,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_event_kind,
   output logic [7:0]                rsp_key_code,
   output logic                      rsp_last_event
);
   import hbk_pkg::*;

   logic             busy_ff;
   logic             busy_in;
   report_entry_type work_ff;
   report_entry_type work_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             kind_ff;
   logic             kind_in;
   logic [7:0]       code_ff;
   logic [7:0]       code_in;
   logic             last_ff;
   logic             last_in;
   logic             advance;
   logic             fire;
   evt_mask_type     pick;
   evt_mask_type     remaining;
   logic             pick_kind;
   logic [7:0]       pick_code;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = busy_ff && advance;
   assign pop       = !busy_ff && q_status.can_pop;
   assign pick      = work_ff.mask & (~work_ff.mask + 1'b1);
   assign remaining = work_ff.mask & ~pick;

   always_comb begin
      pick_kind = 1'b0;
      pick_code = '0;
      for (int i = 0; i < MOD_BITS; i++) begin
         if (pick[i]) begin
            pick_kind = pick_kind | ~work_ff.mods[i];
            pick_code = pick_code | (MOD_BASE_CODE + 8'(i));
         end
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (pick[MOD_BITS + 2*i]) begin
            pick_kind = pick_kind | KIND_RELEASE;
            pick_code = pick_code | work_ff.old_keys[i];
         end
         if (pick[MOD_BITS + 2*i + 1]) begin
            pick_kind = pick_kind | KIND_PRESS;
            pick_code = pick_code | work_ff.new_keys[i];
         end
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      work_in      = work_ff;
      rsp_valid_in = advance ? 1'b0 : rsp_valid_ff;
      kind_in      = kind_ff;
      code_in      = code_ff;
      last_in      = last_ff;
      if (fire) begin
         busy_in      = (remaining != '0);
         work_in.mask = remaining;
         rsp_valid_in = 1'b1;
         kind_in      = pick_kind;
         code_in      = pick_code;
         last_in      = (remaining == '0);
      end else if (pop) begin
         busy_in = 1'b1;
         work_in = pop_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         work_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         work_ff      <= work_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      code_ff <= code_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_key_code   = code_ff;
   assign rsp_last_event = last_ff;

   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (work_ff.mask != '0))
      else $error("busy with no pending events");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !last_ff) |-> busy_ff)
      else $error("report ended without a last event");

   a_one_pick: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> $onehot(pick))
      else $error("event pick not one-hot");

endmodule

### rtl/hid_boot_keyboard_report_differ.sv
// ---------------------------------------------------------------------------
// hid_boot_keyboard_report_differ
// Turns USB HID boot keyboard reports into key press and release events.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one report per transaction: modifier byte and six key
//   slots. A report whose first slot holds the rollover code is taken and
//   dropped; every other report is compared with the stored one.
//   rsp_* carries one event per transaction: kind (0 press, 1 release), the
//   usage code (modifiers as 224 to 231) and a flag on the report's final
//   event. A report that changes nothing gives no events.
//   The first event of a report passes through the report queue, the
//   emitter's work register and the event register before it is valid.
//   The emitter loads one report, then emits one event per cycle while
//   rsp_stall is low, up to 20 events, before it loads the next report.
//   The front takes a report whenever the report queue (QUEUE_DEPTH
//   entries) has room, so it keeps accepting while events still drain.
//   While an event is valid and rsp_stall is high, the event register holds;
//   the emitter and, once the queue is full, req_stall back up behind it.
//   Reset clears the stored report to all zero and empties the queue.
// ---------------------------------------------------------------------------
module hid_boot_keyboard_report_differ #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_modifier_bits,
   input  logic [7:0] req_key_slot_0,
   input  logic [7:0] req_key_slot_1,
   input  logic [7:0] req_key_slot_2,
   input  logic [7:0] req_key_slot_3,
   input  logic [7:0] req_key_slot_4,
   input  logic [7:0] req_key_slot_5,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_event_kind,
   output logic [7:0] rsp_key_code,
   output logic       rsp_last_event
);
   import hbk_pkg::*;

   key_array_type    req_keys;
   queue_status_type q_status;
   logic             push;
   logic             pop;
   report_entry_type push_entry;
   report_entry_type pop_entry;

   assign req_keys[0] = req_key_slot_0;
   assign req_keys[1] = req_key_slot_1;
   assign req_keys[2] = req_key_slot_2;
   assign req_keys[3] = req_key_slot_3;
   assign req_keys[4] = req_key_slot_4;
   assign req_keys[5] = req_key_slot_5;

   hbk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_mods   (req_modifier_bits),
      .req_keys   (req_keys),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   hbk_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   hbk_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .pop_entry      (pop_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_kind (rsp_event_kind),
      .rsp_key_code   (rsp_key_code),
      .rsp_last_event (rsp_last_event)
   );

endmodule
